>>> hdl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, skipped while reset is low
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// the same property, also checked while reset is low
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Constants, tables and round functions shared by the md5 engine modules.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned WordW  = 32;
    localparam int unsigned CountW = 61;
    localparam int unsigned HalfW  = 64;
    localparam int unsigned BufDepth = 64;
    localparam int unsigned BufAw  = 6;
    localparam int unsigned RoundW = 6;

    localparam logic [WordW-1:0] IvA = 32'h67452301;
    localparam logic [WordW-1:0] IvB = 32'hefcdab89;
    localparam logic [WordW-1:0] IvC = 32'h98badcfe;
    localparam logic [WordW-1:0] IvD = 32'h10325476;
    localparam logic [ByteW-1:0] PadByte = 8'h80;

    // controller to round unit
    typedef struct packed {
        logic       start;   // load working words from chain, begin 64 rounds
    } rnd_ctrl_t;

    typedef struct packed {
        logic       busy;
        logic       done;    // chain updated this cycle
    } rnd_stat_t;

    function automatic logic [WordW-1:0] round_k(input logic [RoundW-1:0] r);
        logic [WordW-1:0] k;
        unique case (r)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [RoundW-1:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = '0;
        endcase
        return s;
    endfunction

    // message word index used by round r
    function automatic logic [3:0] round_g(input logic [RoundW-1:0] r);
        logic [3:0] g;
        unique case (r[5:4])
            2'd0: g = r[3:0];
            2'd1: g = 4'(5 * r[3:0] + 1);
            2'd2: g = 4'(3 * r[3:0] + 5);
            2'd3: g = 4'(7 * r[3:0]);
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic logic [WordW-1:0] round_f(input logic [1:0] q,
        input logic [WordW-1:0] b, input logic [WordW-1:0] c,
        input logic [WordW-1:0] d);
        logic [WordW-1:0] f;
        unique case (q)
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (b & d) | (c & ~d);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

>>> hdl/md5_round.sv
// ----------------------------------------------------------------------------
// md5_round
// One md5 round per cycle over a word-wide block memory, chain words kept here.
// Message words are read from a 16x32 memory in the cycle before their round.
// ----------------------------------------------------------------------------
module md5_round (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  md5_pkg::rnd_ctrl_t         ctrl,
    output md5_pkg::rnd_stat_t         stat,
    output logic [3:0]                 rd_addr,
    input  logic [md5_pkg::WordW-1:0]  rd_word,
    input  logic                       chain_init,
    output logic [4*md5_pkg::WordW-1:0] chain
);
    import md5_pkg::*;

    logic [WordW-1:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic [WordW-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [RoundW-1:0] rnd_reg;
    logic             run_reg, fin_reg;
    logic [WordW-1:0] sum, rot, t;
    logic [4:0]       sh;

    // word for round rnd_reg was read last cycle; read next round's word now
    assign rd_addr = ctrl.start ? round_g('0) : round_g(rnd_reg + 1'b1);
    assign sum = a_reg + round_f(rnd_reg[5:4], b_reg, c_reg, d_reg) + rd_word
                 + round_k(rnd_reg);
    assign sh  = round_s(rnd_reg);
    assign rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    assign t   = b_reg + rot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            rnd_reg <= '0;
            ca_reg <= IvA; cb_reg <= IvB; cc_reg <= IvC; cd_reg <= IvD;
        end else begin
            fin_reg <= 1'b0;
            if (ctrl.start) begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
                a_reg <= ca_reg; b_reg <= cb_reg; c_reg <= cc_reg; d_reg <= cd_reg;
            end else if (run_reg) begin
                a_reg <= d_reg; b_reg <= t; c_reg <= b_reg; d_reg <= c_reg;
                rnd_reg <= rnd_reg + 1'b1;
                if (rnd_reg == RoundW'(63)) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
            if (fin_reg) begin
                ca_reg <= ca_reg + a_reg; cb_reg <= cb_reg + b_reg;
                cc_reg <= cc_reg + c_reg; cd_reg <= cd_reg + d_reg;
            end else if (chain_init) begin
                ca_reg <= IvA; cb_reg <= IvB; cc_reg <= IvC; cd_reg <= IvD;
            end
        end
    end

    assign stat.busy = run_reg | fin_reg;
    assign stat.done = fin_reg;
    assign chain = {cd_reg, cc_reg, cb_reg, ca_reg};

    `include "assert_macros.svh"
    `ASSERT_CLK(a_no_start_busy, aclk, aresetn, ctrl.start |-> !(run_reg || fin_reg),
        "compression started while busy")
    `ASSERT_CLK(a_fin_after_last, aclk, aresetn,
        (run_reg && rnd_reg == RoundW'(63)) |=> fin_reg, "missing chain update")
endmodule

>>> hdl/md5_digest_engine_unit.sv
// md5 engine: one byte item per cycle while a block fills; a full block
// stalls input while the single shared round unit runs its 64 rounds,
// reads ahead and updates the chain. a final item adds padding: one or
// two blocks, each a fill sweep of up to 64 bytes plus the rounds, then two
// digest items. synchronous active-low reset restores the initial chain.
// ----------------------------------------------------------------------------
// md5_digest_engine_unit
// Streaming md5 hash engine: byte items in, two 64-bit digest items out.
// ----------------------------------------------------------------------------
module md5_digest_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // is_final
    input  logic        s_tuser,   // no_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest_half
    output logic        m_tlast    // is_last_half
);
    import md5_pkg::*;

    localparam logic [2:0] ST_IN   = 3'd0;
    localparam logic [2:0] ST_HASH = 3'd1;
    localparam logic [2:0] ST_PAD  = 3'd2;
    localparam logic [2:0] ST_PHSH = 3'd3;
    localparam logic [2:0] ST_OUT0 = 3'd4;
    localparam logic [2:0] ST_OUT1 = 3'd5;

    logic [2:0]        st_reg;
    logic [CountW-1:0] cnt_reg;
    logic [BufAw-1:0]  pos_reg;
    logic              second_reg; // padding needs a length block after this one
    logic              start_reg;
    logic [WordW-1:0]  rd_word_reg;
    logic [3:0]        rd_addr;
    logic [3:0]        wr_addr;
    logic [1:0]        wr_lane;
    logic              wr_en;
    logic [ByteW-1:0]  wr_byte;
    logic [63:0]       bits;
    logic [4*WordW-1:0] chain;
    rnd_ctrl_t         ctrl;
    rnd_stat_t         stat;
    logic              acc;
    logic              chain_init;
    logic [127:0]      dig;

    // four byte-lane memories: words filled bytewise one lane at a time, read whole
    logic [ByteW-1:0]  lane_mem [4][16];

    assign acc = s_tvalid && s_tready;
    assign s_tready = (st_reg == ST_IN);
    assign bits = {cnt_reg, 3'b000};

    md5_round u_round (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .stat(stat),
        .rd_addr(rd_addr), .rd_word(rd_word_reg), .chain_init(chain_init),
        .chain(chain)
    );
    assign ctrl.start = start_reg;

    // write port: one byte into one lane per cycle
    always_comb begin
        wr_en = 1'b0;
        wr_byte = '0;
        unique case (st_reg)
            ST_IN: begin
                wr_en = acc && !s_tuser;
                wr_byte = s_tdata;
            end
            ST_PAD: begin
                wr_en = 1'b1;
                if (pos_reg == cnt_reg[5:0] && !second_reg)
                    wr_byte = PadByte;
                else if (pos_reg >= 6'd56 && (second_reg || cnt_reg[5:0] < 6'd56))
                    wr_byte = bits[8*(pos_reg[2:0]) +: 8];
                else
                    wr_byte = '0;
            end
            default: ;
        endcase
    end
    assign wr_addr = st_reg == ST_IN ? cnt_reg[5:2] : pos_reg[5:2];
    assign wr_lane = st_reg == ST_IN ? cnt_reg[1:0] : pos_reg[1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) lane_mem[wr_lane][wr_addr] <= wr_byte;
        rd_word_reg <= {lane_mem[3][rd_addr], lane_mem[2][rd_addr],
                        lane_mem[1][rd_addr], lane_mem[0][rd_addr]};
    end
    assign dig = chain;

    always_comb begin
        chain_init = 1'b0;
        if (st_reg == ST_OUT1 && m_tready) chain_init = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IN;
            cnt_reg <= '0;
            pos_reg <= '0;
            second_reg <= 1'b0;
            start_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            unique case (st_reg)
                ST_IN: if (acc) begin
                    if (!s_tuser) cnt_reg <= cnt_reg + 1'b1;
                    if (!s_tuser && cnt_reg[5:0] == 6'd63) begin
                        start_reg <= 1'b1;
                        st_reg <= ST_HASH;
                        second_reg <= s_tlast;
                    end else if (s_tlast) begin
                        st_reg <= ST_PAD;
                        pos_reg <= s_tuser ? cnt_reg[5:0] : cnt_reg[5:0] + 1'b1;
                        second_reg <= 1'b0;
                    end
                end
                ST_HASH: if (stat.done) begin
                    if (second_reg) begin
                        st_reg <= ST_PAD;
                        pos_reg <= '0;
                        second_reg <= 1'b0;
                    end else st_reg <= ST_IN;
                end
                ST_PAD: begin
                    pos_reg <= pos_reg + 1'b1;
                    if (pos_reg == 6'd63) begin
                        start_reg <= 1'b1;
                        st_reg <= ST_PHSH;
                    end
                end
                ST_PHSH: if (stat.done) begin
                    if (cnt_reg[5:0] >= 6'd56 && !second_reg) begin
                        second_reg <= 1'b1;
                        pos_reg <= '0;
                        st_reg <= ST_PAD;
                    end else st_reg <= ST_OUT0;
                end
                ST_OUT0: if (m_tready) st_reg <= ST_OUT1;
                ST_OUT1: if (m_tready) begin
                    st_reg <= ST_IN;
                    cnt_reg <= '0;
                    second_reg <= 1'b0;
                end
                default: st_reg <= ST_IN;
            endcase
        end
    end

    assign m_tvalid = (st_reg == ST_OUT0) || (st_reg == ST_OUT1);
    assign m_tlast  = (st_reg == ST_OUT1);
    assign m_tdata  = m_tlast ?
        {dig[71:64], dig[79:72], dig[87:80], dig[95:88],
         dig[103:96], dig[111:104], dig[119:112], dig[127:120]} :
        {dig[7:0], dig[15:8], dig[23:16], dig[31:24],
         dig[39:32], dig[47:40], dig[55:48], dig[63:56]};

    `include "assert_macros.svh"
    `ASSERT_CLK(a_no_in_while_out, aclk, aresetn, m_tvalid |-> !s_tready,
        "input taken during digest output")
    `ASSERT_CLK(a_start_idle, aclk, aresetn, start_reg |-> !stat.busy,
        "block start while rounds running")
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (s_tready && !m_tvalid),
        "not idle after reset")
endmodule
